>>> design/assert_macros.svh
// assertion macros used by the checker file pfb_checker.sv
// no dependencies; expects clk and rst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is low
`define ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond) \
    `ASSERT_PROP(lbl, !(cond))

`endif

>>> design/pfb_pkg.sv
// types, codes and helper functions for the page frame buffer blitter
// no dependencies; used by pfb_decode and page_framebuffer_blitter
`default_nettype none

package pfb_pkg;

    localparam logic [3:0] MODE_DRAW    = 4'd0;
    localparam logic [3:0] MODE_MIRROR  = 4'd1;
    localparam logic [3:0] MODE_CLEAR   = 4'd2;
    localparam logic [3:0] MODE_OUTLINE = 4'd3;
    localparam logic [3:0] MODE_SET_PX  = 4'd4;
    localparam logic [3:0] MODE_CLR_PX  = 4'd5;
    localparam logic [3:0] MODE_DITHER  = 4'd6;
    localparam logic [3:0] MODE_WRITE   = 4'd7;
    localparam logic [3:0] MODE_READ    = 4'd8;

    localparam logic [7:0] DITHER_LEVELS = 8'd16;

    localparam logic [3:0] BAYER [16] = '{
        4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_OR,
        OP_ANDN,
        OP_XOR,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPPER,
        ST_LOWER
    } state_t;

    // what one item does to its upper and lower page bytes
    typedef struct packed {
        logic       up_en;
        logic       lo_en;
        op_t        op;
        logic [7:0] up_bits;
        logic [7:0] lo_bits;
    } ctl_t;

    function automatic logic [3:0] bayer_at(input logic [3:0] idx);
        return BAYER[idx];
    endfunction

    function automatic logic op_writes(input op_t op);
        return (op == OP_OR) || (op == OP_ANDN) || (op == OP_XOR) || (op == OP_WRITE);
    endfunction

    function automatic logic [7:0] apply_op(input op_t op, input logic [7:0] cur,
                                            input logic [7:0] bits);
        logic [7:0] res;
        case (op)
            OP_OR:    res = cur | bits;
            OP_ANDN:  res = cur & ~bits;
            OP_XOR:   res = cur ^ bits;
            OP_WRITE: res = bits;
            default:  res = cur;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/pfb_ram.sv
// frame memory: one write port and one read port, read data registered
// no dependencies
`default_nettype none

module pfb_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds between reads so a stalled sequencer can still use it
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/pfb_decode.sv
// item decode: target column, pages, addresses and byte masks for one item
// depends on pfb_pkg
`default_nettype none

module pfb_decode
    import pfb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64,
    localparam int PAGES = FRAME_HEIGHT / 8,
    localparam int DEPTH = FRAME_WIDTH * PAGES,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic        [3:0]    mode,
    input  wire logic signed [15:0]   x_pos,
    input  wire logic signed [15:0]   y_pos,
    input  wire logic        [7:0]    column_index,
    input  wire logic        [7:0]    sprite_width,
    input  wire logic        [7:0]    column_bits,
    input  wire logic        [7:0]    left_bits,
    input  wire logic        [7:0]    right_bits,
    input  wire logic        [7:0]    dither_level,
    output ctl_t                      ctl,
    output logic             [AW-1:0] up_addr,
    output logic             [AW-1:0] lo_addr
);

    localparam int CW = $clog2(FRAME_WIDTH);
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic signed [17:0] FW_S    = 18'(FRAME_WIDTH);
    localparam logic signed [13:0] PAGES_S = 14'(PAGES);
    localparam logic [AW-1:0]      FW_A    = AW'(FRAME_WIDTH);

    logic signed [17:0] x_ext;
    logic signed [17:0] px_draw;
    logic signed [17:0] px_mirr;
    logic signed [17:0] col_s;
    logic               col_ok;
    logic signed [13:0] page_up;
    logic signed [13:0] page_lo;
    logic               up_pg_ok;
    logic               lo_pg_ok;
    logic               in_frame;
    logic [2:0]         shift;
    logic [7:0]         l_term;
    logic [7:0]         r_term;
    logic [7:0]         ring;
    logic [7:0]         src;
    logic [15:0]        shifted;
    logic [7:0]         dither_mask;

    assign x_ext   = {{2{x_pos[15]}}, x_pos};
    assign px_draw = x_ext + $signed({10'd0, column_index});
    assign px_mirr = x_ext + $signed({10'd0, sprite_width}) - 18'sd1
                     - $signed({10'd0, column_index});

    always_comb
    begin
        if (mode == MODE_MIRROR)
        begin
            col_s = px_mirr;
        end
        else if (mode == MODE_DRAW || mode == MODE_CLEAR || mode == MODE_OUTLINE)
        begin
            col_s = px_draw;
        end
        else
        begin
            col_s = x_ext;
        end
    end

    assign col_ok   = (col_s >= 18'sd0) && (col_s < FW_S);
    assign page_up  = {y_pos[15], y_pos[15:3]};
    assign page_lo  = page_up + 14'sd1;
    assign up_pg_ok = (page_up >= 14'sd0) && (page_up < PAGES_S);
    assign lo_pg_ok = (page_lo >= 14'sd0) && (page_lo < PAGES_S);
    assign in_frame = col_ok && up_pg_ok;
    assign shift    = y_pos[2:0];

    assign up_addr = AW'(AW'(page_up[PW-1:0]) * FW_A) + AW'(col_s[CW-1:0]);
    assign lo_addr = AW'(AW'(page_lo[PW-1:0]) * FW_A) + AW'(col_s[CW-1:0]);

    // outline: 4-neighbour ring around the set pixels, neighbors gated at sprite edges
    assign l_term = (column_index != 8'd0) ? left_bits : 8'd0;
    assign r_term = (({1'b0, column_index} + 9'd1) < {1'b0, sprite_width}) ? right_bits : 8'd0;
    assign ring   = column_bits | (column_bits << 1) | (column_bits >> 1) | l_term | r_term;
    assign src    = (mode == MODE_OUTLINE) ? (ring & ~column_bits) : column_bits;
    assign shifted = {8'd0, src} << shift;

    // page rows are multiples of eight, so the bayer row is the low two bits of the bit index
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            dither_mask[b] = {4'd0, bayer_at({2'(b), x_pos[1:0]})} >= dither_level;
        end
    end

    always_comb
    begin
        ctl = '{up_en: 1'b0, lo_en: 1'b0, op: OP_NONE, up_bits: 8'd0, lo_bits: 8'd0};
        case (mode)
            MODE_DRAW, MODE_MIRROR, MODE_CLEAR, MODE_OUTLINE:
            begin
                ctl.up_en   = col_ok && up_pg_ok;
                ctl.lo_en   = col_ok && (shift != 3'd0) && lo_pg_ok;
                ctl.op      = (mode == MODE_CLEAR) ? OP_ANDN : OP_OR;
                ctl.up_bits = shifted[7:0];
                ctl.lo_bits = shifted[15:8];
            end
            MODE_SET_PX, MODE_CLR_PX:
            begin
                ctl.up_en   = in_frame;
                ctl.op      = (mode == MODE_CLR_PX) ? OP_ANDN : OP_OR;
                ctl.up_bits = 8'd1 << shift;
            end
            MODE_DITHER:
            begin
                ctl.up_en   = in_frame && (dither_level < DITHER_LEVELS);
                ctl.op      = OP_XOR;
                ctl.up_bits = dither_mask;
            end
            MODE_WRITE:
            begin
                ctl.up_en   = in_frame;
                ctl.op      = OP_WRITE;
                ctl.up_bits = column_bits;
            end
            MODE_READ:
            begin
                ctl.up_en = in_frame;
                ctl.op    = OP_READ;
            end
            default:
            begin
                ctl.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/page_framebuffer_blitter.sv
// top level of the page frame buffer blitter: sequencer, result register, memory
// depends on pfb_pkg, pfb_decode and pfb_ram
`default_nettype none

// Monochrome frame buffer of FRAME_WIDTH columns by FRAME_HEIGHT rows, stored as
// vertical 8-pixel page bytes (bit 0 is the top row of the page) in one memory of
// FRAME_WIDTH*FRAME_HEIGHT/8 bytes. Each input item is one operation (sprite column
// draw, mirrored draw, clear, outline, pixel set or clear, dither invert, byte write,
// byte read) and gives exactly one result item. After reset the block zeroes the
// memory one byte per cycle with s_axis_tready low. Every touched byte is read from
// the memory and written back in the state that follows (ST_UPPER, then ST_LOWER
// when a sprite column also lands in the page byte below and that byte lies inside
// the frame); the second page byte is read while the first is written. The result
// sits in an output register, so the next item is accepted while the previous
// result waits.
module page_framebuffer_blitter
    import pfb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_pos, y_pos, column_index, sprite_width, column_bits, left_bits,
    // right_bits, dither_level
    input  wire logic [79:0] s_axis_tdata,
    // mode
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data, upper_hit, lower_hit, zero fill
    output logic      [15:0] m_axis_tdata
);

    localparam int PAGES = FRAME_HEIGHT / 8;
    localparam int DEPTH = FRAME_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    ctl_t          ctl_reg, ctl_next;
    logic [AW-1:0] up_addr_reg, up_addr_next;
    logic [AW-1:0] lo_addr_reg, lo_addr_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_up_reg, out_up_next;
    logic          out_lo_reg, out_lo_next;

    ctl_t          dec_ctl;
    logic [AW-1:0] dec_up_addr;
    logic [AW-1:0] dec_lo_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic          load_out;

    pfb_decode #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_decode (
        .mode         (s_axis_tuser),
        .x_pos        (s_axis_tdata[15:0]),
        .y_pos        (s_axis_tdata[31:16]),
        .column_index (s_axis_tdata[39:32]),
        .sprite_width (s_axis_tdata[47:40]),
        .column_bits  (s_axis_tdata[55:48]),
        .left_bits    (s_axis_tdata[63:56]),
        .right_bits   (s_axis_tdata[71:64]),
        .dither_level (s_axis_tdata[79:72]),
        .ctl          (dec_ctl),
        .up_addr      (dec_up_addr),
        .lo_addr      (dec_lo_addr)
    );

    pfb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl_next;
        up_addr_reg  <= up_addr_next;
        lo_addr_reg  <= lo_addr_next;
        out_data_reg <= out_data_next;
        out_up_reg   <= out_up_next;
        out_lo_reg   <= out_lo_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ctl_next     = ctl_reg;
        up_addr_next = up_addr_reg;
        lo_addr_next = lo_addr_reg;
        ram_we       = 1'b0;
        ram_waddr    = up_addr_reg;
        ram_wdata    = apply_op(ctl_reg.op, ram_rdata, ctl_reg.up_bits);
        ram_re       = 1'b0;
        ram_raddr    = dec_up_addr;
        load_out     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'd0;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ram_re       = dec_ctl.up_en;
                    ctl_next     = dec_ctl;
                    up_addr_next = dec_up_addr;
                    lo_addr_next = dec_lo_addr;
                    state_next   = ST_UPPER;
                end
            end
            ST_UPPER:
            begin
                if (ctl_reg.lo_en)
                begin
                    // write the upper byte back while the lower page byte is read
                    ram_we     = ctl_reg.up_en && op_writes(ctl_reg.op);
                    ram_re     = 1'b1;
                    ram_raddr  = lo_addr_reg;
                    state_next = ST_LOWER;
                end
                else if (out_free)
                begin
                    ram_we     = ctl_reg.up_en && op_writes(ctl_reg.op);
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOWER:
            begin
                ram_waddr = lo_addr_reg;
                ram_wdata = apply_op(ctl_reg.op, ram_rdata, ctl_reg.lo_bits);
                if (out_free)
                begin
                    ram_we     = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_up_next    = out_up_reg;
        out_lo_next    = out_lo_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = (ctl_reg.up_en && ctl_reg.op == OP_READ) ? ram_rdata : 8'd0;
            out_up_next    = ctl_reg.up_en;
            out_lo_next    = ctl_reg.lo_en;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_lo_reg, out_up_reg, out_data_reg};

endmodule

`default_nettype wire

>>> design/pfb_checker.sv
// port-level checks for page_framebuffer_blitter, attached by bind
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module pfb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // a result waiting for the sink keeps its value
    `ASSERT_PROP(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // one item at a time: no accept in the cycle right after an accept
    `ASSERT_PROP(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // read data only comes from a byte that was in range
    `ASSERT_NEVER(a_read_hit, m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 && !m_axis_tdata[8])

    // fill bits above the result fields stay zero
    `ASSERT_NEVER(a_fill_zero, m_axis_tvalid && m_axis_tdata[15:10] != 6'd0)

endmodule

bind page_framebuffer_blitter pfb_checker u_pfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/page_framebuffer_blitter_check.sv
// result checker for the page frame buffer blitter: keeps a shadow of the frame store,
// predicts one result per accepted command item and compares the result stream
// depends on pfb_pkg for the mode codes, the bayer matrix and the dither level count
`timescale 1ns / 100ps

module page_framebuffer_blitter_check
    import pfb_pkg::*;
#(
    parameter int FRAME_W = 128,
    parameter int FRAME_H = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // x_pos, y_pos, column_index, sprite_width, column_bits, left_bits,
    // right_bits, dither_level
    input  logic [79:0] s_axis_tdata,
    // mode
    input  logic [3:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data, upper_hit, lower_hit, zero fill
    input  logic [15:0] m_axis_tdata,
    output int          mismatches,
    output int          outstanding
);

    localparam int PAGES = FRAME_H / 8;

    typedef struct packed {
        logic [3:0]        mode;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [7:0]        column_index;
        logic [7:0]        sprite_width;
        logic [7:0]        column_bits;
        logic [7:0]        left_bits;
        logic [7:0]        right_bits;
        logic [7:0]        dither_level;
    } blit_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       upper_hit;
        logic       lower_hit;
    } blit_result_t;

    logic [7:0]   shadow_frame [FRAME_W * PAGES];
    blit_result_t expected_results [$];

    function automatic logic on_screen(input int col, input int page);
        return col >= 0 && col < FRAME_W && page >= 0 && page < PAGES;
    endfunction

    // OR or AND-NOT one page byte, reports whether the byte exists
    function automatic logic touch_byte(input int col, input int page, input logic [7:0] bits,
                                        input logic clr);
        int addr;
        if (!on_screen(col, page))
            return 1'b0;
        addr = page * FRAME_W + col;
        if (clr)
            shadow_frame[addr] = shadow_frame[addr] & ~bits;
        else
            shadow_frame[addr] = shadow_frame[addr] | bits;
        return 1'b1;
    endfunction

    task automatic blit_predict(input blit_cmd_t cmd, output blit_result_t res);
        int         xs;
        int         page;
        int         shift;
        int         col;
        int         b;
        logic [7:0] src;
        logic [7:0] ring;
        logic [7:0] lb;
        logic [7:0] rb;
        logic [7:0] up_bits;
        logic [7:0] lo_bits;
        logic [7:0] mask;
        logic       clr;
        res   = '0;
        xs    = int'($signed(cmd.x_pos));
        page  = int'($signed(cmd.y_pos)) >>> 3;
        shift = int'(cmd.y_pos[2:0]);
        clr   = (cmd.mode == MODE_CLEAR) || (cmd.mode == MODE_CLR_PX);
        case (cmd.mode)
            MODE_DRAW, MODE_MIRROR, MODE_CLEAR, MODE_OUTLINE:
            begin
                if (cmd.mode == MODE_MIRROR)
                    col = xs + int'(cmd.sprite_width) - 1 - int'(cmd.column_index);
                else
                    col = xs + int'(cmd.column_index);
                src = cmd.column_bits;
                if (cmd.mode == MODE_OUTLINE)
                begin
                    lb   = (cmd.column_index != 0) ? cmd.left_bits : 8'h00;
                    rb   = (int'(cmd.column_index) + 1 < int'(cmd.sprite_width)) ?
                           cmd.right_bits : 8'h00;
                    ring = cmd.column_bits | (cmd.column_bits << 1) | (cmd.column_bits >> 1) |
                           lb | rb;
                    src  = ring & ~cmd.column_bits;
                end
                up_bits = src << shift;
                lo_bits = src >> (8 - shift);
                if (col >= 0 && col < FRAME_W)
                begin
                    res.upper_hit = touch_byte(col, page, up_bits, clr);
                    if (shift != 0)
                        res.lower_hit = touch_byte(col, page + 1, lo_bits, clr);
                end
            end
            MODE_SET_PX, MODE_CLR_PX:
            begin
                mask          = 8'h01 << shift;
                res.upper_hit = touch_byte(xs, page, mask, clr);
            end
            MODE_DITHER:
            begin
                if (cmd.dither_level < DITHER_LEVELS && on_screen(xs, page))
                begin
                    mask = 8'h00;
                    for (b = 0; b < 8; b++)
                        if (BAYER[((page * 8 + b) & 3) * 4 + (xs & 3)] >= cmd.dither_level)
                            mask[b] = 1'b1;
                    shadow_frame[page * FRAME_W + xs] ^= mask;
                    res.upper_hit = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                if (on_screen(xs, page))
                begin
                    shadow_frame[page * FRAME_W + xs] = cmd.column_bits;
                    res.upper_hit = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (on_screen(xs, page))
                begin
                    res.read_data = shadow_frame[page * FRAME_W + xs];
                    res.upper_hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blit_cmd_t    cmd;
        blit_result_t want;
        blit_result_t got;
        if (!rst_n)
        begin
            foreach (shadow_frame[i])
                shadow_frame[i] = 8'h00;
            expected_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                       s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[55:48],
                       s_axis_tdata[63:56], s_axis_tdata[71:64], s_axis_tdata[79:72]};
                blit_predict(cmd, want);
                expected_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9]};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result item with nothing expected: read_data %h up %b lo %b",
                                 $realtime, got.read_data, got.upper_hit, got.lower_hit);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data || got.upper_hit !== want.upper_hit ||
                        got.lower_hit !== want.lower_hit)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: expected read_data %h up %b lo %b, got %h %b %b",
                                     $realtime, want.read_data, want.upper_hit, want.lower_hit,
                                     got.read_data, got.upper_hit, got.lower_hit);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> test/page_framebuffer_blitter_test.sv
// top of the blitter testbench: clock, reset, command stimulus and result stalls
// depends on pfb_pkg, page_framebuffer_blitter and page_framebuffer_blitter_check
`timescale 1ns / 100ps

module page_framebuffer_blitter_test;
    import pfb_pkg::*;

    localparam int FRAME_W = 128;
    localparam int FRAME_H = 64;
    localparam int ITEM_GOAL = 600;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;

    // codes the block treats as no-ops
    localparam logic [3:0] MODE_SPARE_LO = 4'd9;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   sent = 0;
    int   cycles = 0;
    logic steady = 1'b0;

    page_framebuffer_blitter #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    page_framebuffer_blitter_check #(
        .FRAME_W(FRAME_W),
        .FRAME_H(FRAME_H)
    ) i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stalls, none during the steady stretch
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 15);

    task automatic send_op(input logic [3:0] mode, input int x, input int y, input int ci,
                           input int w, input int bits, input int lb, input int rb,
                           input int lvl);
        while (!steady && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {lvl[7:0], rb[7:0], lb[7:0], bits[7:0], w[7:0], ci[7:0],
                          y[15:0], x[15:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        steady = (sent >= 200 && sent < 350);
    endtask

    initial
    begin
        logic [7:0] sprite [16];
        int         w;
        int         x;
        int         y;
        int         kind;
        logic [3:0] mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: each mode, edges of the frame and of the fields
        send_op(MODE_READ,    0, 0, 0, 0, 0, 0, 0, 0);
        send_op(MODE_WRITE,   5, 8, 0, 0, 'hA5, 0, 0, 0);
        send_op(MODE_READ,    5, 8, 0, 0, 0, 0, 0, 0);
        send_op(MODE_DRAW,    10, 3, 0, 1, 'hFF, 0, 0, 0);
        send_op(MODE_MIRROR,  20, 16, 2, 5, 'h81, 0, 0, 0);
        send_op(MODE_CLEAR,   10, 3, 0, 1, 'h0F, 0, 0, 0);
        send_op(MODE_READ,    10, 8, 0, 0, 0, 0, 0, 0);
        // outline at first, last and a middle column
        send_op(MODE_OUTLINE, 30, 20, 0, 3, 'h18, 'hFF, 'h24, 0);
        send_op(MODE_OUTLINE, 30, 20, 2, 3, 'h18, 'h42, 'hFF, 0);
        send_op(MODE_OUTLINE, 30, 21, 1, 3, 'h81, 'h3C, 'h66, 0);
        send_op(MODE_SET_PX,  127, 63, 0, 0, 0, 0, 0, 0);
        send_op(MODE_READ,    127, 56, 0, 0, 0, 0, 0, 0);
        send_op(MODE_CLR_PX,  127, 63, 0, 0, 0, 0, 0, 0);
        // dither: full invert, no-op levels, partial
        send_op(MODE_DITHER,  40, 0, 0, 0, 0, 0, 0, 0);
        send_op(MODE_DITHER,  40, 0, 0, 0, 0, 0, 0, 16);
        send_op(MODE_DITHER,  41, 8, 0, 0, 0, 0, 0, 255);
        send_op(MODE_DITHER,  43, 8, 0, 0, 0, 0, 0, 7);
        // straddle off the bottom and off the top
        send_op(MODE_DRAW,    50, 61, 0, 1, 'hFF, 0, 0, 0);
        send_op(MODE_DRAW,    51, -3, 0, 1, 'hFF, 0, 0, 0);
        send_op(MODE_DRAW,    -32768, -32768, 255, 255, 'hFF, 'hFF, 'hFF, 255);
        send_op(MODE_WRITE,   32767, 32767, 0, 0, 'hFF, 0, 0, 0);
        send_op(MODE_READ,    32767, -32768, 0, 0, 0, 0, 0, 0);
        // index past the width, zero byte, mirror of width zero
        send_op(MODE_DRAW,    -50, 12, 100, 3, 'h5A, 0, 0, 0);
        send_op(MODE_DRAW,    60, 5, 0, 1, 'h00, 0, 0, 0);
        send_op(MODE_MIRROR,  10, 0, 0, 0, 'hC3, 0, 0, 0);
        send_op(MODE_SPARE_LO, 1, 1, 0, 0, 'hFF, 'hFF, 'hFF, 0);
        send_op(MODE_SPARE_HI, 2, 2, 255, 255, 'hFF, 'hFF, 'hFF, 255);

        while (sent < ITEM_GOAL)
        begin
            kind = $urandom_range(99);
            x    = $urandom_range(143) - 8;
            y    = $urandom_range(79) - 8;
            if (kind < 35)
            begin
                // a whole sprite drawn column by column with consistent neighbours
                w    = $urandom_range(12, 1);
                mode = 4'($urandom_range(3));
                for (int c = 0; c < w; c++)
                    sprite[c] = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(255));
                for (int c = 0; c < w; c++)
                    send_op(mode, x, y, c, w, sprite[c], (c > 0) ? sprite[c - 1] : 0,
                            (c + 1 < w) ? sprite[c + 1] : 0, $urandom_range(255));
            end
            else if (kind < 60)
                send_op(MODE_READ, x, y, 0, 0, 0, 0, 0, 0);
            else if (kind < 70)
                send_op(MODE_WRITE, x, y, 0, 0, $urandom_range(255), 0, 0, 0);
            else if (kind < 80)
                send_op($urandom_range(1) ? MODE_SET_PX : MODE_CLR_PX, x, y, 0, 0, 0, 0, 0, 0);
            else if (kind < 88)
                send_op(MODE_DITHER, x, y, 0, 0, 0, 0, 0, $urandom_range(20));
            else if (kind < 95)
                send_op(4'($urandom_range(15)), $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255));
            else
                send_op(4'($urandom_range(3)), x, y, $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/pfb_pkg.sv
design/pfb_ram.sv
design/pfb_decode.sv
design/page_framebuffer_blitter.sv
design/pfb_checker.sv
test/page_framebuffer_blitter_check.sv
test/page_framebuffer_blitter_test.sv
